// ===== hw/rtl/bpc_pkg.sv =====
// Types, constants and arithmetic helpers for the pressure compensation pipeline.
`default_nettype none

package bpc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_CAL_AS = 3'd0;
	localparam logic [2:0] REG_CAL_AU = 3'd1;
	localparam logic [2:0] REG_CAL_B  = 3'd2;
	localparam logic [2:0] REG_CAL_M  = 3'd3;
	localparam logic [2:0] REG_OSS    = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Divider depths: temperature quotient fits 27 bits, pressure quotient 32
	localparam int TQ_W    = 27;
	localparam int TD_STEPS = TQ_W;
	localparam int PD_STEPS = 32;

	localparam logic signed [31:0] C_B6_OFS   = 32'sd4000;
	localparam logic signed [31:0] C_P_K1     = 32'sd3038;
	localparam logic signed [31:0] C_P_K2     = -32'sd7537;
	localparam logic signed [31:0] C_P_K3     = 32'sd3791;
	localparam logic [31:0]        C_B7_SCALE = 32'd50000;
	localparam logic signed [31:0] C_B4_OFS   = 32'sd32768;

	// Temperature divider stage
	typedef struct packed {
		logic [31:0]        rem;
		logic [TQ_W-1:0]    acc;
		logic [31:0]        dvs;
		logic               neg;
		logic signed [31:0] x1;
		logic [23:0]        up;
		logic               dz;
	} tdiv_t;

	// Pressure divider stage
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] acc;
		logic [31:0] dvs;
		logic        big;
		logic        dz;
		logic        tdz;
		logic [15:0] temp;
	} pdiv_t;

	function automatic logic signed [31:0] sx16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic signed [31:0] zx16(input logic [15:0] x);
		return {16'b0, x};
	endfunction

	// Wrapping 32-bit product
	function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] f;
		f = a * b;
		return f[31:0];
	endfunction

	// Signed divide by 2^k, truncating toward zero
	function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
		input logic [4:0] k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

	// One restoring step of the temperature divider
	function automatic tdiv_t tdiv_step(input tdiv_t s);
		tdiv_t n;
		logic [32:0] t;
		n = s;
		t = {s.rem, s.acc[TQ_W-1]};
		if (t >= {1'b0, s.dvs}) begin
			t = t - {1'b0, s.dvs};
			n.acc = {s.acc[TQ_W-2:0], 1'b1};
		end else begin
			n.acc = {s.acc[TQ_W-2:0], 1'b0};
		end
		n.rem = t[31:0];
		return n;
	endfunction

	// One restoring step of the pressure divider
	function automatic pdiv_t pdiv_step(input pdiv_t s);
		pdiv_t n;
		logic [32:0] t;
		n = s;
		t = {s.rem, s.acc[31]};
		if (t >= {1'b0, s.dvs}) begin
			t = t - {1'b0, s.dvs};
			n.acc = {s.acc[30:0], 1'b1};
		end else begin
			n.acc = {s.acc[30:0], 1'b0};
		end
		n.rem = t[31:0];
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpc_ifs.sv =====
// Channel interfaces: raw samples, compensated results, configuration writes.
`default_nettype none

interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temp;
	logic [23:0] raw_pressure;
	modport source (output valid, raw_temp, raw_pressure, input ready);
	modport sink (input valid, raw_temp, raw_pressure, output ready);
endinterface

interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_tenths;
	logic signed [31:0] pressure_pa;
	logic               div_error;
	modport source (output valid, temp_tenths, pressure_pa, div_error, input ready);
	modport sink (input valid, temp_tenths, pressure_pa, div_error, output ready);
endinterface

interface bpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]   index;
	logic [bpc_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/barometer_pressure_compensation_top.sv =====
// Pipelined barometric temperature and pressure compensation.
//
// Channels: sample (raw_temp, raw_pressure in), result (temp_tenths,
// pressure_pa, div_error out), cfg (index, data register writes; always
// ready, writes to unknown indexes are dropped). Write cfg only while idle.
// Each transferred sample gives exactly one result.
// The path holds 75 register stages, and the first is loaded at the
// transfer edge. They are two bit-per-stage restoring dividers (27 stages
// for temperature, 32 for pressure) plus 16 arithmetic stages, with at most
// one multiply in series per stage.
// Throughput: one sample per cycle while the receiver takes results.
// The result register plus a skid register decouple the sides: a stalled
// receiver first fills the skid register, then the whole pipeline freezes
// with its contents intact, and sample.ready drops until the skid drains.
// Reset clears all valid bits and loads zero into every calibration
// register; payload registers are not reset.
// A zero divisor in either divide gives div_error = 1 with zero results.
`default_nettype none

module barometer_pressure_compensation_top (
	input  wire          clk,
	input  wire          arst_n,
	bpc_in_if.sink       sample,
	bpc_out_if.source    result,
	bpc_cfg_if.sink      cfg
);

	localparam int TD = bpc_pkg::TD_STEPS;
	localparam int PD = bpc_pkg::PD_STEPS;

	// Configuration registers
	logic [47:0] cal_as_q, cal_au_q;
	logic [31:0] cal_b_q, cal_m_q;
	logic [1:0]  oss_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_as_q <= '0;
			cal_au_q <= '0;
			cal_b_q  <= '0;
			cal_m_q  <= '0;
			oss_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bpc_pkg::REG_CAL_AS: cal_as_q <= cfg.data;
				bpc_pkg::REG_CAL_AU: cal_au_q <= cfg.data;
				bpc_pkg::REG_CAL_B:  cal_b_q  <= cfg.data[31:0];
				bpc_pkg::REG_CAL_M:  cal_m_q  <= cfg.data[31:0];
				bpc_pkg::REG_OSS:    oss_q    <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Coefficient fields
	logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = cal_as_q[47:32];
	assign ac2 = cal_as_q[31:16];
	assign ac3 = cal_as_q[15:0];
	assign ac4 = cal_au_q[47:32];
	assign ac5 = cal_au_q[31:16];
	assign ac6 = cal_au_q[15:0];
	assign b1  = cal_b_q[31:16];
	assign b2  = cal_b_q[15:0];
	assign mc  = cal_m_q[31:16];
	assign md  = cal_m_q[15:0];

	// Pipeline advance: frozen only while the skid register is full
	logic skid_v_q, res_v_q;
	logic en, push, take;
	assign en = !skid_v_q;
	assign sample.ready = en;

	// Valid bits
	logic v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14;
	logic [TD:0] tv_s;
	logic [PD:0] pv_s;

	// Payload registers
	logic signed [31:0] prod_s1;
	logic [23:0]        up_s1, up_s3, up_s4, up_s5, up_s6, up_s7, up_s8;
	bpc_pkg::tdiv_t     tdiv_s [0:TD];
	bpc_pkg::pdiv_t     pdiv_s [0:PD];
	logic signed [31:0] b5_s3, b6_s3;
	logic signed [31:0] sqr_s4, ma2_s4, ma3_s4;
	logic signed [31:0] sq_s5, x2a_s5, x1c_s5;
	logic signed [31:0] mb2_s6, mb1_s6, x2a_s6, x1c_s6;
	logic signed [31:0] b3a_s7, x3s_s7;
	logic signed [31:0] b3_s8, f_s8;
	logic signed [31:0] m4_s9, bd_s9;
	logic [31:0]        b4_s10, b7_s10;
	logic signed [31:0] p_s11, pd_s11, m7_s11;
	logic signed [31:0] p_s12, sqp_s12, x2_s12;
	logic signed [31:0] p_s13, m30_s13, x2_s13;
	logic signed [31:0] p_s14, sum_s14;
	logic [15:0]        temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [15:0]        temp_s11, temp_s12, temp_s13, temp_s14;
	logic               tdz_s3, tdz_s4, tdz_s5, tdz_s6, tdz_s7, tdz_s8, tdz_s9, tdz_s10;
	logic               err_s11, err_s12, err_s13, err_s14;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0;
			tv_s <= '0;
			pv_s <= '0;
		end else if (en) begin
			v_s1  <= sample.valid;
			tv_s  <= {tv_s[TD-1:0], v_s1};
			v_s3  <= tv_s[TD];
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			pv_s  <= {pv_s[PD-1:0], v_s10};
			v_s11 <= pv_s[PD];
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// Stage-local combinational values
	logic signed [31:0] d1, x1_t, den_t, num_t, x2_t, b5_t, wide_b3;
	logic signed [32:0] tw, tsh;
	logic [15:0]        temp_t;
	logic [26:0]        tq;
	logic [31:0]        pq;

	always_comb begin
		d1    = bpc_pkg::zx16(sample.raw_temp) - bpc_pkg::zx16(ac6);
		x1_t  = bpc_pkg::sdiv_p2(prod_s1, 5'd15);
		den_t = x1_t + bpc_pkg::sx16(md);
		num_t = bpc_pkg::sx16(mc) <<< 11;
		tq    = tdiv_s[TD].acc;
		x2_t  = tdiv_s[TD].neg ? -$signed({5'b0, tq}) : $signed({5'b0, tq});
		b5_t  = tdiv_s[TD].x1 + x2_t;
		// floor((B5 + 8) / 16), saturated
		tw    = {b5_s3[31], b5_s3} + 33'sd8;
		tsh   = tw >>> 4;
		if (tsh > 33'sd32767)
			temp_t = 16'h7fff;
		else if (tsh < -33'sd32768)
			temp_t = 16'h8000;
		else
			temp_t = tsh[15:0];
		wide_b3 = b3a_s7 << oss_q;
		pq    = pdiv_s[PD].big ? {pdiv_s[PD].acc[30:0], 1'b0} : pdiv_s[PD].acc;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: (UT - AC6) * AC5 and UP
			prod_s1 <= bpc_pkg::mul32(d1, bpc_pkg::zx16(ac5));
			up_s1   <= 24'(sample.raw_pressure >> (4'd8 - {2'b0, oss_q}));

			// temperature divider load: (MC * 2048) / (X1 + MD)
			tdiv_s[0].rem <= '0;
			tdiv_s[0].acc <= num_t[31] ? 27'(-num_t) : num_t[26:0];
			tdiv_s[0].dvs <= den_t[31] ? 32'(-den_t) : den_t;
			tdiv_s[0].neg <= num_t[31] ^ den_t[31];
			tdiv_s[0].x1  <= x1_t;
			tdiv_s[0].up  <= up_s1;
			tdiv_s[0].dz  <= (den_t == 32'sd0);
			for (int i = 0; i < TD; i++)
				tdiv_s[i+1] <= bpc_pkg::tdiv_step(tdiv_s[i]);

			// s3: B5, B6
			b5_s3  <= b5_t;
			b6_s3  <= b5_t - bpc_pkg::C_B6_OFS;
			up_s3  <= tdiv_s[TD].up;
			tdz_s3 <= tdiv_s[TD].dz;

			// s4: B6 products, temperature result
			sqr_s4  <= bpc_pkg::mul32(b6_s3, b6_s3);
			ma2_s4  <= bpc_pkg::mul32(bpc_pkg::sx16(ac2), b6_s3);
			ma3_s4  <= bpc_pkg::mul32(bpc_pkg::sx16(ac3), b6_s3);
			temp_s4 <= temp_t;
			up_s4   <= up_s3;
			tdz_s4  <= tdz_s3;

			// s5: scale
			sq_s5   <= bpc_pkg::sdiv_p2(sqr_s4, 5'd12);
			x2a_s5  <= bpc_pkg::sdiv_p2(ma2_s4, 5'd11);
			x1c_s5  <= bpc_pkg::sdiv_p2(ma3_s4, 5'd13);
			temp_s5 <= temp_s4;
			up_s5   <= up_s4;
			tdz_s5  <= tdz_s4;

			// s6: B2 and B1 terms
			mb2_s6  <= bpc_pkg::mul32(bpc_pkg::sx16(b2), sq_s5);
			mb1_s6  <= bpc_pkg::mul32(bpc_pkg::sx16(b1), sq_s5);
			x2a_s6  <= x2a_s5;
			x1c_s6  <= x1c_s5;
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			tdz_s6  <= tdz_s5;

			// s7: sums for B3 and X3
			b3a_s7  <= (bpc_pkg::sx16(ac1) <<< 2) + bpc_pkg::sdiv_p2(mb2_s6, 5'd11) + x2a_s6;
			x3s_s7  <= x1c_s6 + bpc_pkg::sdiv_p2(mb1_s6, 5'd16) + 32'sd2;
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			tdz_s7  <= tdz_s6;

			// s8: B3 and X3 + 32768
			b3_s8   <= bpc_pkg::sdiv_p2(wide_b3 + 32'sd2, 5'd2);
			f_s8    <= bpc_pkg::sdiv_p2(x3s_s7, 5'd2) + bpc_pkg::C_B4_OFS;
			temp_s8 <= temp_s7;
			up_s8   <= up_s7;
			tdz_s8  <= tdz_s7;

			// s9: AC4 product, UP - B3
			m4_s9   <= bpc_pkg::mul32(bpc_pkg::zx16(ac4), f_s8);
			bd_s9   <= $signed({8'b0, up_s8}) - b3_s8;
			temp_s9 <= temp_s8;
			tdz_s9  <= tdz_s8;

			// s10: B4, B7
			b4_s10   <= {15'b0, m4_s9[31:15]};
			b7_s10   <= bpc_pkg::mul32(bd_s9, $signed(bpc_pkg::C_B7_SCALE >> oss_q));
			temp_s10 <= temp_s9;
			tdz_s10  <= tdz_s9;

			// pressure divider load: B7 * 2 / B4, or B7 / B4 then doubled
			pdiv_s[0].rem  <= '0;
			pdiv_s[0].acc  <= b7_s10[31] ? b7_s10 : {b7_s10[30:0], 1'b0};
			pdiv_s[0].dvs  <= b4_s10;
			pdiv_s[0].big  <= b7_s10[31];
			pdiv_s[0].dz   <= (b4_s10 == 32'd0);
			pdiv_s[0].tdz  <= tdz_s10;
			pdiv_s[0].temp <= temp_s10;
			for (int j = 0; j < PD; j++)
				pdiv_s[j+1] <= bpc_pkg::pdiv_step(pdiv_s[j]);

			// s11: p, p / 256, -7537 * p
			p_s11    <= pq;
			pd_s11   <= bpc_pkg::sdiv_p2(pq, 5'd8);
			m7_s11   <= bpc_pkg::mul32(bpc_pkg::C_P_K2, pq);
			temp_s11 <= pdiv_s[PD].temp;
			err_s11  <= pdiv_s[PD].dz | pdiv_s[PD].tdz;

			// s12: square, and -7537 * p / 65536
			sqp_s12  <= bpc_pkg::mul32(pd_s11, pd_s11);
			x2_s12   <= bpc_pkg::sdiv_p2(m7_s11, 5'd16);
			p_s12    <= p_s11;
			temp_s12 <= temp_s11;
			err_s12  <= err_s11;

			// s13: * 3038
			m30_s13  <= bpc_pkg::mul32(sqp_s12, bpc_pkg::C_P_K1);
			x2_s13   <= x2_s12;
			p_s13    <= p_s12;
			temp_s13 <= temp_s12;
			err_s13  <= err_s12;

			// s14: correction sum
			sum_s14  <= bpc_pkg::sdiv_p2(m30_s13, 5'd16) + x2_s13 + bpc_pkg::C_P_K3;
			p_s14    <= p_s13;
			temp_s14 <= temp_s13;
			err_s14  <= err_s13;
		end
	end

	// Final result
	logic signed [31:0] press_n;
	logic signed [15:0] temp_n;
	assign press_n = err_s14 ? 32'sd0 : p_s14 + bpc_pkg::sdiv_p2(sum_s14, 5'd4);
	assign temp_n  = err_s14 ? 16'sd0 : $signed(temp_s14);

	// Result register and skid register
	logic signed [15:0] res_temp_q, skid_temp_q;
	logic signed [31:0] res_press_q, skid_press_q;
	logic               res_err_q, skid_err_q;

	assign push = en & v_s14;
	assign take = res_v_q & result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!res_v_q || take)
				res_v_q <= skid_v_q | push;
			if (skid_v_q) begin
				if (take)
					skid_v_q <= 1'b0;
			end else if (push && res_v_q && !take) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!res_v_q || take) begin
			res_temp_q  <= skid_v_q ? skid_temp_q : temp_n;
			res_press_q <= skid_v_q ? skid_press_q : press_n;
			res_err_q   <= skid_v_q ? skid_err_q : err_s14;
		end
		if (push && res_v_q && !take) begin
			skid_temp_q  <= temp_n;
			skid_press_q <= press_n;
			skid_err_q   <= err_s14;
		end
	end

	assign result.valid       = res_v_q;
	assign result.temp_tenths = res_temp_q;
	assign result.pressure_pa = res_press_q;
	assign result.div_error   = res_err_q;

endmodule

`default_nettype wire

// ===== verif/bpc_tb_ifs.sv =====
// Testbench item types: one raw sample and one expected reading.
`default_nettype none

package bpc_tb_types;

	// One raw sample as the testbench drives it
	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_pressure;
	} raw_sample_t;

	// One compensated reading as the testbench expects it
	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic signed [31:0] pressure_pa;
		logic               div_error;
	} reading_t;
endpackage

`default_nettype wire

// ===== verif/tb_barometer_pressure_compensation_top.sv =====
// Barometric compensation testbench: directed and random samples checked against a local model.
`default_nettype none

module tb_barometer_pressure_compensation_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 74;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpc_in_if  sample();
	bpc_out_if result();
	bpc_cfg_if cfg();

	barometer_pressure_compensation_top uut (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// Calibration shadow
	logic [47:0] cal_as, cal_au;
	logic [31:0] cal_b, cal_m;
	logic [1:0]  oss;

	bpc_tb_types::raw_sample_t pending_samples[$];
	bpc_tb_types::reading_t    expected_readings[$];
	int errors = 0;
	int checked = 0;
	int div_errors_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int phase = -1;
	logic hold = 1'b0;
	longint cycles = 0;

	function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] q;
		q = 64'(a) / 64'(b);
		return q[31:0];
	endfunction

	// Fixed-point compensation of one sample under the current calibration
	function automatic bpc_tb_types::reading_t compensate(input bpc_tb_types::raw_sample_t s);
		bpc_tb_types::reading_t r;
		logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic signed [31:0] ut, up, x1, x2, x3, b5, b6, b3, sq, den, p;
		logic [31:0] b4, b7, q, tmp;
		logic signed [63:0] t;
		ac1 = {{16{cal_as[47]}}, cal_as[47:32]};
		ac2 = {{16{cal_as[31]}}, cal_as[31:16]};
		ac3 = {{16{cal_as[15]}}, cal_as[15:0]};
		ac4 = {16'b0, cal_au[47:32]};
		ac5 = {16'b0, cal_au[31:16]};
		ac6 = {16'b0, cal_au[15:0]};
		b1 = {{16{cal_b[31]}}, cal_b[31:16]};
		b2 = {{16{cal_b[15]}}, cal_b[15:0]};
		mc = {{16{cal_m[31]}}, cal_m[31:16]};
		md = {{16{cal_m[15]}}, cal_m[15:0]};
		ut = {16'b0, s.raw_temp};
		up = {8'b0, s.raw_pressure >> (8 - oss)};
		r = '0;
		r.div_error = 1'b1;
		x1 = tdiv((ut - ac6) * ac5, 32768);
		den = x1 + md;
		if (den == 0)
			return r;
		x2 = tdiv(mc * 2048, den);
		b5 = x1 + x2;
		b6 = b5 - 4000;
		sq = tdiv(b6 * b6, 4096);
		x1 = tdiv(b2 * sq, 2048);
		x2 = tdiv(ac2 * b6, 2048);
		x3 = x1 + x2;
		b3 = (ac1 * 4 + x3) << oss;
		b3 = tdiv(b3 + 2, 4);
		x1 = tdiv(ac3 * b6, 8192);
		x2 = tdiv(b1 * sq, 65536);
		x3 = tdiv(x1 + x2 + 2, 4);
		tmp = x3 + 32768;
		b4 = (ac4 * tmp) / 32'd32768;
		if (b4 == 0)
			return r;
		b7 = (up - b3) * (32'd50000 >> oss);
		if (b7 < 32'h8000_0000)
			q = (b7 * 2) / b4;
		else
			q = (b7 / b4) * 2;
		p = q;
		x1 = tdiv(p, 256) * tdiv(p, 256);
		x1 = tdiv(x1 * 3038, 65536);
		x2 = tdiv(-32'sd7537 * p, 65536);
		p = p + tdiv(x1 + x2 + 3791, 16);
		t = (64'(b5) + 8) >>> 4;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		r.temp_tenths = t[15:0];
		r.pressure_pa = p;
		r.div_error = 1'b0;
		return r;
	endfunction

	// Sample driver: predicts at each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.raw_temp <= '0;
			sample.raw_pressure <= '0;
		end else begin
			if (sample.valid && sample.ready)
				expected_readings.push_back(compensate({sample.raw_temp, sample.raw_pressure}));
			if ((!sample.valid || sample.ready) ) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					bpc_tb_types::raw_sample_t s;
					s = pending_samples.pop_front();
					sample.valid <= 1'b1;
					sample.raw_temp <= s.raw_temp;
					sample.raw_pressure <= s.raw_pressure;
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering samples
	initial begin
		wait (phase == 4 && pending_samples.size() > 0);
		@(posedge clk);
		hold <= 1'b1;
		repeat (300) @(posedge clk);
		hold <= 1'b0;
	end

	// Result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (result.valid && result.ready) begin
				bpc_tb_types::reading_t e;
				checked++;
				if (result.div_error)
					div_errors_seen++;
				if (expected_readings.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer temp=%0d p=%0d err=%0b", $time,
						result.temp_tenths, result.pressure_pa, result.div_error);
				end else begin
					e = expected_readings.pop_front();
					if (e.temp_tenths !== result.temp_tenths) begin
						errors++;
						$display("%0t: temp_tenths expected %0d actual %0d", $time,
							e.temp_tenths, result.temp_tenths);
					end
					if (e.pressure_pa !== result.pressure_pa) begin
						errors++;
						$display("%0t: pressure_pa expected %0d actual %0d", $time,
							e.pressure_pa, result.pressure_pa);
					end
					if (e.div_error !== result.div_error) begin
						errors++;
						$display("%0t: div_error expected %0b actual %0b", $time,
							e.div_error, result.div_error);
					end
				end
			end
			if (hold)
				result.ready <= 1'b0;
			else
				result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Timeout
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			bpc_pkg::REG_CAL_AS: cal_as = value;
			bpc_pkg::REG_CAL_AU: cal_au = value;
			bpc_pkg::REG_CAL_B:  cal_b = value[31:0];
			bpc_pkg::REG_CAL_M:  cal_m = value[31:0];
			bpc_pkg::REG_OSS:    oss = value[1:0];
			default: ;
		endcase
	endtask

	// Typical factory calibration with random spread, or fully random words when wild
	task automatic load_calibration(input logic [1:0] o, input bit wild);
		if (wild) begin
			write_reg(bpc_pkg::REG_CAL_AS, 48'({$urandom, $urandom}));
			write_reg(bpc_pkg::REG_CAL_AU, 48'({$urandom, $urandom}));
			write_reg(bpc_pkg::REG_CAL_B, 48'($urandom));
			write_reg(bpc_pkg::REG_CAL_M, 48'($urandom));
		end else begin
			write_reg(bpc_pkg::REG_CAL_AS, {16'(408 + $urandom_range(200) - 100),
				16'(-72 + $urandom_range(40) - 20), 16'(-14383 + $urandom_range(400) - 200)});
			write_reg(bpc_pkg::REG_CAL_AU, {16'(32741 + $urandom_range(2000) - 1000),
				16'(32757 + $urandom_range(2000) - 1000), 16'(23153 + $urandom_range(2000) - 1000)});
			write_reg(bpc_pkg::REG_CAL_B, {16'b0, 16'(6190 + $urandom_range(200) - 100),
				16'(4 + $urandom_range(8))});
			write_reg(bpc_pkg::REG_CAL_M, {16'b0, 16'(-8711 + $urandom_range(400) - 200),
				16'(2868 + $urandom_range(400) - 200)});
		end
		write_reg(bpc_pkg::REG_OSS, 48'(o));
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || sample.valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic queue_random(input int n, input bit typical);
		bpc_tb_types::raw_sample_t s;
		repeat (n) begin
			if (typical) begin
				s.raw_temp = 16'(27898 + $urandom_range(8000) - 4000);
				s.raw_pressure = 24'(($urandom_range(30000, 40000) << 8) + $urandom_range(255));
			end else begin
				s.raw_temp = 16'($urandom);
				s.raw_pressure = 24'($urandom);
			end
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		bpc_tb_types::raw_sample_t s;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cal_as = '0; cal_au = '0; cal_b = '0; cal_m = '0; oss = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset calibration: zero divisors everywhere
		s = '0; pending_samples.push_back(s);
		s = '1; pending_samples.push_back(s);
		drain();

		// Directed extremes under typical calibration, every oversampling step
		for (int o = 0; o < 4; o++) begin
			load_calibration(2'(o), 1'b0);
			s = '{16'h0000, 24'h000000}; pending_samples.push_back(s);
			s = '{16'hFFFF, 24'hFFFFFF}; pending_samples.push_back(s);
			s = '{16'h6CFA, 24'h5D2380}; pending_samples.push_back(s);
			s = '{16'h8000, 24'h800000}; pending_samples.push_back(s);
			drain();
		end
		// Zero pressure divisor: ac4 = 0
		write_reg(bpc_pkg::REG_CAL_AU, {16'h0000, 16'd32757, 16'd23153});
		s = '{16'h6CFA, 24'h5D2380}; pending_samples.push_back(s);
		drain();
		// Zero temperature divisor: X1 + md = 0 with ut = ac6
		write_reg(bpc_pkg::REG_CAL_AU, {16'd32741, 16'd32757, 16'd23153});
		write_reg(bpc_pkg::REG_CAL_M, {16'b0, 16'hDDF9, 16'h0000});
		s = '{16'd23153, 24'h5D2380}; pending_samples.push_back(s);
		drain();
		// Extreme calibration words; unknown index is dropped
		write_reg(bpc_pkg::REG_CAL_AS, 48'hFFFF_FFFF_FFFF);
		write_reg(bpc_pkg::REG_CAL_B, 48'h0000_8000_7FFF);
		write_reg(REG_UNUSED, 48'h1234_5678_9ABC);
		s = '{16'hFFFF, 24'h000001}; pending_samples.push_back(s);
		drain();

		// Random phases over idling profiles and calibrations
		for (int ph = 0; ph < 6; ph++) begin
			phase = ph;
			send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 54 : 0;
			recv_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 23 : 0;
			load_calibration(2'($urandom_range(3)), ph == 5);
			queue_random(220, 1'b1);
			queue_random(60, ph == 5 ? 1'b0 : 1'b1);
			drain();
		end

		$display("Checked %0d readings, %0d with a divisor error, over directed corners and",
			checked, div_errors_seen);
		$display("six random calibration phases with sender and receiver stalls.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_ifs.sv
hw/rtl/barometer_pressure_compensation_top.sv
verif/bpc_tb_ifs.sv
verif/tb_barometer_pressure_compensation_top.sv
